### hdl/undirected_adjacency_matrix_store_unit_assert.svh
// assertion macros used by the graph store rtl
`ifndef UNDIRECTED_ADJACENCY_MATRIX_STORE_UNIT_ASSERT_SVH
`define UNDIRECTED_ADJACENCY_MATRIX_STORE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UAMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uams: same-cycle check failed");

// next-cycle implication, checked out of reset
`define UAMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uams: next-cycle check failed");

`endif

### hdl/uams_pkg.sv
// types and constants of the graph store
`timescale 1ns / 1ps
package uams_pkg;

  localparam int ID_W    = 6;
  localparam int ID_SPAN = 64;

  typedef enum logic [1:0] {
    CMD_ADD_VERTEX = 2'd0,
    CMD_ADD_EDGE   = 2'd1,
    CMD_LIST       = 2'd2,
    CMD_CHECK      = 2'd3
  } cmd_t;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

endpackage

### hdl/uams_in_if.sv
// command channel of the graph store
`timescale 1ns / 1ps
interface uams_in_if import uams_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      cmd;
  logic [ID_W-1:0] vertex_a;
  logic [ID_W-1:0] vertex_b;

  modport source (output valid, output cmd, output vertex_a, output vertex_b, input ready);
  modport sink   (input valid, input cmd, input vertex_a, input vertex_b, output ready);
endinterface

### hdl/uams_out_if.sv
// result channel of the graph store
`timescale 1ns / 1ps
interface uams_out_if import uams_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            status;
  logic [ID_W-1:0] neighbour;
  logic            has_neighbour;
  logic            last;

  modport source (output valid, output status, output neighbour, output has_neighbour,
                  output last, input ready);
  modport sink   (input valid, input status, input neighbour, input has_neighbour,
                  input last, output ready);
endinterface

### hdl/uams_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module uams_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/undirected_adjacency_matrix_store_unit.sv
// Undirected graph store: one present bit per vertex in flip-flops and one adjacency row per
// vertex in a ram, each row with a valid bit that reset clears, so an unwritten row reads as
// empty and no clearing pass is needed. Commands are taken one at a time. Add edge is a
// read-modify-write of row a, then of row b, through the ram's single write port. A neighbour
// listing scans the fetched row one bit per cycle, from vertex 0 up to and including the highest
// neighbour, while the result channel is not stalled; a stalled result channel holds the sequence.
`timescale 1ns / 1ps
`include "undirected_adjacency_matrix_store_unit_assert.svh"
module undirected_adjacency_matrix_store_unit import uams_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  uams_in_if.sink    in_ch,
  uams_out_if.source out_ch
);

  localparam int NV = (MAX_VERTICES < ID_SPAN) ? MAX_VERTICES : ID_SPAN;
  localparam int AW = $clog2(NV);
  localparam logic [ID_W:0] NV_L = (ID_W + 1)'(NV);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EDGE_A,
    ST_EDGE_RB,
    ST_EDGE_B,
    ST_LIST_RD,
    ST_SCAN
  } st_t;

  st_t             state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [ID_W-1:0] va_r, va_nxt;
  logic [ID_W-1:0] vb_r, vb_nxt;
  logic [NV-1:0]   present_r, present_nxt;
  logic [NV-1:0]   row_valid_r, row_valid_nxt;
  logic            rd_valid_r, rd_valid_nxt;
  logic [NV-1:0]   rem_r, rem_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_status_r, out_status_nxt;
  logic [ID_W-1:0] out_nb_r, out_nb_nxt;
  logic            out_has_r, out_has_nxt;
  logic            out_last_r, out_last_nxt;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [NV-1:0]   ram_wdata, ram_rdata;

  logic            slot_free, emit;
  logic            a_in_range, b_in_range, a_present, b_present;
  logic [AW-1:0]   a_idx, b_idx;
  logic [NV-1:0]   a_bit, b_bit, idx_bit, row_eff, row_mask;

  uams_ram #(.WIDTH(NV), .DEPTH(NV)) u_rows (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.neighbour     = out_nb_r;
  assign out_ch.has_neighbour = out_has_r;
  assign out_ch.last          = out_last_r;

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign a_in_range = ({1'b0, va_r} < NV_L);
  assign b_in_range = ({1'b0, vb_r} < NV_L);
  assign a_idx      = va_r[AW-1:0];
  assign b_idx      = vb_r[AW-1:0];
  assign a_present  = a_in_range && present_r[a_idx];
  assign b_present  = b_in_range && present_r[b_idx];
  assign a_bit      = NV'(1) << a_idx;
  assign b_bit      = NV'(1) << b_idx;
  assign idx_bit    = NV'(1) << idx_r;
  // a row never written reads as empty
  assign row_eff    = rd_valid_r ? ram_rdata : '0;
  assign row_mask   = row_eff & present_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    va_nxt         = va_r;
    vb_nxt         = vb_r;
    present_nxt    = present_r;
    row_valid_nxt  = row_valid_r;
    rd_valid_nxt   = rd_valid_r;
    rem_nxt        = rem_r;
    idx_nxt        = idx_r;
    out_status_nxt = out_status_r;
    out_nb_nxt     = out_nb_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;
    emit           = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = a_idx;
    ram_wdata      = row_eff | b_bit;
    ram_re         = 1'b0;
    ram_raddr      = a_idx;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = cmd_t'(in_ch.cmd);
          va_nxt    = in_ch.vertex_a;
          vb_nxt    = in_ch.vertex_b;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_r)
          CMD_ADD_VERTEX: begin
            if (slot_free) begin
              if (a_in_range) begin
                present_nxt[a_idx] = 1'b1;
              end
              emit           = 1'b1;
              out_status_nxt = a_in_range ? STATUS_OK : STATUS_NOT_FOUND;
              out_nb_nxt     = '0;
              out_has_nxt    = 1'b0;
              out_last_nxt   = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end
          CMD_CHECK: begin
            if (slot_free) begin
              emit           = 1'b1;
              out_status_nxt = a_present ? STATUS_OK : STATUS_NOT_FOUND;
              out_nb_nxt     = '0;
              out_has_nxt    = 1'b0;
              out_last_nxt   = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end
          CMD_ADD_EDGE: begin
            if (a_present && b_present) begin
              ram_re       = 1'b1;
              ram_raddr    = a_idx;
              rd_valid_nxt = row_valid_r[a_idx];
              state_nxt    = ST_EDGE_A;
            end else if (slot_free) begin
              emit           = 1'b1;
              out_status_nxt = STATUS_NOT_FOUND;
              out_nb_nxt     = '0;
              out_has_nxt    = 1'b0;
              out_last_nxt   = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end
          CMD_LIST: begin
            if (a_in_range) begin
              ram_re       = 1'b1;
              ram_raddr    = a_idx;
              rd_valid_nxt = row_valid_r[a_idx];
              state_nxt    = ST_LIST_RD;
            end else if (slot_free) begin
              emit           = 1'b1;
              out_status_nxt = STATUS_OK;
              out_nb_nxt     = '0;
              out_has_nxt    = 1'b0;
              out_last_nxt   = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_EDGE_A: begin
        ram_we               = 1'b1;
        ram_waddr            = a_idx;
        ram_wdata            = row_eff | b_bit;
        row_valid_nxt[a_idx] = 1'b1;
        state_nxt            = ST_EDGE_RB;
      end
      ST_EDGE_RB: begin
        ram_re       = 1'b1;
        ram_raddr    = b_idx;
        rd_valid_nxt = row_valid_r[b_idx];
        state_nxt    = ST_EDGE_B;
      end
      ST_EDGE_B: begin
        if (slot_free) begin
          ram_we               = 1'b1;
          ram_waddr            = b_idx;
          ram_wdata            = row_eff | a_bit;
          row_valid_nxt[b_idx] = 1'b1;
          emit                 = 1'b1;
          out_status_nxt       = STATUS_OK;
          out_nb_nxt           = '0;
          out_has_nxt          = 1'b0;
          out_last_nxt         = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      ST_LIST_RD: begin
        if (row_mask != '0) begin
          rem_nxt   = row_mask;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end else if (slot_free) begin
          emit           = 1'b1;
          out_status_nxt = STATUS_OK;
          out_nb_nxt     = '0;
          out_has_nxt    = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (rem_r[idx_r]) begin
          if (slot_free) begin
            emit           = 1'b1;
            out_status_nxt = STATUS_OK;
            out_nb_nxt     = ID_W'(idx_r);
            out_has_nxt    = 1'b1;
            // last when no higher neighbour is left
            out_last_nxt   = ((rem_r & ~idx_bit) == '0);
            rem_nxt        = rem_r & ~idx_bit;
            idx_nxt        = idx_r + AW'(1);
            if ((rem_r & ~idx_bit) == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      present_r   <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    va_r         <= va_nxt;
    vb_r         <= vb_nxt;
    rd_valid_r   <= rd_valid_nxt;
    rem_r        <= rem_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_nb_r     <= out_nb_nxt;
    out_has_r    <= out_has_nxt;
    out_last_r   <= out_last_nxt;
  end

  // the scan only runs while some neighbour is still to be sent
  `UAMS_ASSERT_IMPL(a_scan_nonempty, clk, rst_n, state_r == ST_SCAN, rem_r != '0)
  // a listed neighbour is a present vertex
  `UAMS_ASSERT_IMPL(a_scan_present, clk, rst_n, emit && state_r == ST_SCAN, present_r[idx_r])
  // rows are written only by the edge steps
  `UAMS_ASSERT_IMPL(a_we_edge, clk, rst_n, ram_we,
                    state_r == ST_EDGE_A || state_r == ST_EDGE_B)
  // a written row is marked valid from then on
  `UAMS_ASSERT_NEXT(a_row_valid, clk, rst_n, ram_we, row_valid_r[$past(ram_waddr)])

endmodule
